/* sv/rcov_pkg.sv */
// ----------------------------------------------------------------------------
// rcov_pkg: shared types and constants
// Types and constants used by the covariance accumulator and its bit-serial
// arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rcov_pkg;

  // width of the serial unit's operands
  localparam int WORD_BITS = 64;
  // one bit per cycle, one step per operand bit
  localparam int STEPS     = WORD_BITS;
  localparam int STEP_BITS = $clog2(STEPS);

  localparam int MEAN_BITS = 32;
  localparam int VAR_BITS  = 40;
  localparam int EXT_BITS  = 16;
  localparam int CNT_OUT_BITS = 32;
  localparam int OUT_BITS  = CNT_OUT_BITS + 2 * MEAN_BITS + 3 * VAR_BITS + 4 * EXT_BITS;

  typedef enum logic [1:0] {
    MODE_MUL = 2'b01,
    MODE_DIV = 2'b10
  } ser_mode_e;

  typedef struct packed {
    logic      start;
    ser_mode_e mode;
  } ser_req_t;

  // operations of one sample's sequence
  typedef enum logic [3:0] {
    OP_QX = 4'd0,   // dx / n
    OP_QY = 4'd1,   // dy / n
    OP_MX = 4'd2,   // dx * (X - new mean)
    OP_MY = 4'd3,   // dy * (Y - new mean)
    OP_MP = 4'd4,   // dx * dy
    OP_QP = 4'd5,   // p / n
    OP_VX = 4'd6,   // x deviation sum / (n-1)
    OP_VY = 4'd7,   // y deviation sum / (n-1)
    OP_CV = 4'd8    // co-deviation sum / (n-1)
  } op_e;

endpackage

`default_nettype wire

/* sv/rcov_serial_unit.sv */
// ----------------------------------------------------------------------------
// rcov_serial_unit: shared bit-serial multiplier / divider
// Unsigned 64x64 shift-add multiply or 64/64 restoring divide, one bit per
// cycle. Result is valid when done_o pulses and holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module rcov_serial_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire rcov_pkg::ser_req_t                  req_i,
  input  wire logic [rcov_pkg::WORD_BITS-1:0]      opa_i,  // multiplicand / dividend
  input  wire logic [rcov_pkg::WORD_BITS-1:0]      opb_i,  // multiplier / divisor
  output logic                                     done_o,
  output logic [rcov_pkg::WORD_BITS-1:0]           hi_o,   // product high half
  output logic [rcov_pkg::WORD_BITS-1:0]           lo_o    // product low half / quotient
);

  logic [rcov_pkg::WORD_BITS:0]       hi_q, hi_d;
  logic [rcov_pkg::WORD_BITS-1:0]     lo_q, lo_d;
  logic [rcov_pkg::WORD_BITS-1:0]     opd_q;
  rcov_pkg::ser_mode_e                mode_q;
  logic [rcov_pkg::STEP_BITS-1:0]     cnt_q;
  logic                               run_q;
  logic                               done_q;

  logic [rcov_pkg::WORD_BITS:0]       sum;
  logic [rcov_pkg::WORD_BITS:0]       rem;
  logic                               ge;

  always_comb begin
    sum  = hi_q + (lo_q[0] ? {1'b0, opd_q} : '0);
    rem  = {hi_q[rcov_pkg::WORD_BITS-1:0], lo_q[rcov_pkg::WORD_BITS-1]};
    ge   = rem >= {1'b0, opd_q};
    hi_d = hi_q;
    lo_d = lo_q;
    unique case (mode_q)
      rcov_pkg::MODE_MUL: begin
        hi_d = {1'b0, sum[rcov_pkg::WORD_BITS:1]};
        lo_d = {sum[0], lo_q[rcov_pkg::WORD_BITS-1:1]};
      end
      rcov_pkg::MODE_DIV: begin
        hi_d = ge ? (rem - {1'b0, opd_q}) : rem;
        lo_d = {lo_q[rcov_pkg::WORD_BITS-2:0], ge};
      end
      default: begin
        hi_d = hi_q;
        lo_d = lo_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rcov_pkg::STEP_BITS'(rcov_pkg::STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      hi_q   <= '0;
      if (req_i.mode == rcov_pkg::MODE_DIV) begin
        lo_q  <= opa_i;
        opd_q <= opb_i;
      end else begin
        lo_q  <= opb_i;
        opd_q <= opa_i;
      end
    end else if (run_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign hi_o   = hi_q[rcov_pkg::WORD_BITS-1:0];
  assign lo_o   = lo_q;

endmodule

`default_nettype wire

/* sv/running_covariance_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// running_covariance_accumulator_unit: online mean / variance / covariance
// Welford update of count, means, deviation sums and extremes per (x, y)
// sample, with variances and covariance emitted after every sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one word per sample pair, x in the low half of tdata.
//   Output stream m_axis: one word per input word: count, means (Q16.16),
//   variances and covariance (8 fraction bits), extremes; tuser = count full.
//   One sample is worked at a time. A shared bit-serial multiply/divide unit
//   runs 64 steps per operation, each with a launch and an update step.
//   A normal sample runs 9 operations before its result goes to the emit step;
//   the next input word is taken once the result is in the output register.
//   The first sample (or any with count <= 1) goes from accept straight to
//   the emit step; a sample arriving at full count runs only the 3 output
//   divisions before the emit step.
//   The result sits in an output register: the next sample is taken while it
//   waits. If the receiver stalls, the following result holds in the emit
//   step until the output register frees.
//   Reset clears count, means, sums and extremes at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module running_covariance_accumulator_unit #(
  parameter  int SAMPLE_BITS = 16,
  parameter  int COUNT_BITS  = 32,
  parameter  int FRAC_BITS   = 16,
  localparam int InW         = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // sample_x, sample_y
  input  wire logic [InW-1:0]                s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // sample_count, average_x, average_y, variance_x, variance_y, covariance_xy,
  // smallest_x, largest_x, smallest_y, largest_y
  output logic [rcov_pkg::OUT_BITS-1:0]      m_axis_tdata_o,
  // count_full
  output logic [0:0]                         m_axis_tuser_o
);

  localparam int XB = SAMPLE_BITS + FRAC_BITS;          // sample in mean format
  localparam int DB = ((XB > 32) ? XB : 32) + 1;         // deviation width
  localparam int SH = 2 * FRAC_BITS - 8;                 // product scaling
  localparam int WB = rcov_pkg::WORD_BITS;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LAUNCH = 5'b00010,
    ST_BUSY   = 5'b00100,
    ST_APPLY  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
    else                               r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) r = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    else                r = s[63:0];
    return r;
  endfunction

  // ---- state ----
  state_e                         state_q;
  rcov_pkg::op_e                  op_q;
  logic [COUNT_BITS-1:0]          count_q;
  logic signed [31:0]             mean_x_q, mean_y_q;
  logic signed [63:0]             sx_q, sy_q, sxy_q;
  logic signed [SAMPLE_BITS-1:0]  min_x_q, max_x_q, min_y_q, max_y_q;

  // ---- per-sample work registers ----
  logic signed [SAMPLE_BITS-1:0]  x_q, y_q;
  logic signed [DB-1:0]           dx_q, dy_q;
  logic signed [63:0]             p_q;
  logic                           full_q;
  logic [rcov_pkg::VAR_BITS-1:0]  var_x_q, var_y_q, cov_q;

  // ---- output register ----
  logic                           out_valid_q;
  logic [rcov_pkg::OUT_BITS-1:0]  out_data_q;
  logic                           out_full_q;

  // ---- serial unit ----
  rcov_pkg::ser_req_t             req;
  logic [WB-1:0]                  opa, opb, res_hi, res_lo;
  logic                           unit_done;

  rcov_serial_unit u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (unit_done),
    .hi_o   (res_hi),
    .lo_o   (res_lo)
  );

  // ---- input side ----
  logic                           in_acc;
  logic signed [SAMPLE_BITS-1:0]  in_x, in_y;
  logic signed [DB-1:0]           in_xw, in_yw;
  logic [COUNT_BITS-1:0]          n_next;
  logic                           is_full;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_x    = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign in_y    = s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_xw   = DB'(in_x) <<< FRAC_BITS;
  assign in_yw   = DB'(in_y) <<< FRAC_BITS;
  assign is_full = &count_q;
  assign n_next  = count_q + 1'b1;

  // ---- operand selection ----
  logic signed [DB-1:0] xw, yw, ex, ey;
  logic [DB-1:0]        dx_mag, dy_mag, ex_mag, ey_mag;
  logic [63:0]          p_mag, sxy_mag, n64, d64;

  always_comb begin
    xw      = DB'(x_q) <<< FRAC_BITS;
    yw      = DB'(y_q) <<< FRAC_BITS;
    ex      = xw - DB'(mean_x_q);   // mean already updated here
    ey      = yw - DB'(mean_y_q);
    dx_mag  = dx_q[DB-1] ? -dx_q : dx_q;
    dy_mag  = dy_q[DB-1] ? -dy_q : dy_q;
    ex_mag  = ex[DB-1] ? -ex : ex;
    ey_mag  = ey[DB-1] ? -ey : ey;
    p_mag   = p_q[63] ? -p_q : p_q;
    sxy_mag = sxy_q[63] ? -sxy_q : sxy_q;
    n64     = 64'(count_q);
    d64     = 64'(count_q - 1'b1);
  end

  always_comb begin
    req.start = (state_q == ST_LAUNCH);
    req.mode  = rcov_pkg::MODE_DIV;
    opa       = '0;
    opb       = n64;
    unique case (op_q)
      rcov_pkg::OP_QX: begin opa = 64'(dx_mag); opb = n64; end
      rcov_pkg::OP_QY: begin opa = 64'(dy_mag); opb = n64; end
      rcov_pkg::OP_MX: begin
        req.mode = rcov_pkg::MODE_MUL; opa = 64'(dx_mag); opb = 64'(ex_mag);
      end
      rcov_pkg::OP_MY: begin
        req.mode = rcov_pkg::MODE_MUL; opa = 64'(dy_mag); opb = 64'(ey_mag);
      end
      rcov_pkg::OP_MP: begin
        req.mode = rcov_pkg::MODE_MUL; opa = 64'(dx_mag); opb = 64'(dy_mag);
      end
      rcov_pkg::OP_QP: begin opa = p_mag; opb = n64; end
      rcov_pkg::OP_VX: begin opa = sx_q; opb = d64; end
      rcov_pkg::OP_VY: begin opa = sy_q; opb = d64; end
      rcov_pkg::OP_CV: begin opa = sxy_mag; opb = d64; end
      default: begin opa = '0; opb = n64; end
    endcase
  end

  // ---- result post-processing ----
  logic                  q_neg;
  logic [DB-1:0]         q_db;
  logic signed [DB:0]    q_s, m_sum;
  logic signed [31:0]    new_mean;
  logic [127:0]          prod_sh;
  logic [63:0]           r_mag, qp_diff;
  logic                  p_neg;
  logic signed [63:0]    scaled, qp_term;
  logic [rcov_pkg::VAR_BITS-1:0] var_res, cov_res;
  logic signed [63:0]    var_sum;

  always_comb begin
    // mean step: dx / n truncated toward zero
    q_neg    = (op_q == rcov_pkg::OP_QY) ? dy_q[DB-1] : dx_q[DB-1];
    q_db     = res_lo[DB-1:0];
    q_s      = q_neg ? -$signed({1'b0, q_db}) : $signed({1'b0, q_db});
    m_sum    = ((op_q == rcov_pkg::OP_QY) ? (DB+1)'(mean_y_q) : (DB+1)'(mean_x_q)) + q_s;
    new_mean = sat32(48'(m_sum));

    // scaled product, magnitude saturated
    prod_sh  = {res_hi, res_lo} >> SH;
    r_mag    = (|prod_sh[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, prod_sh[62:0]};
    unique case (op_q)
      rcov_pkg::OP_MX: p_neg = dx_q[DB-1] ^ ex[DB-1];
      rcov_pkg::OP_MY: p_neg = dy_q[DB-1] ^ ey[DB-1];
      default:         p_neg = dx_q[DB-1] ^ dy_q[DB-1];
    endcase
    scaled   = p_neg ? -$signed(r_mag) : $signed(r_mag);

    // co-deviation term p - p / n
    qp_diff  = p_mag - res_lo;
    qp_term  = p_q[63] ? -$signed(qp_diff) : $signed(qp_diff);

    // variance output: zero for non-positive sums, saturate to 40 bits
    var_sum  = (op_q == rcov_pkg::OP_VY) ? sy_q : sx_q;
    if (var_sum <= 0)                          var_res = '0;
    else if (|res_lo[63:rcov_pkg::VAR_BITS])   var_res = '1;
    else                                       var_res = res_lo[rcov_pkg::VAR_BITS-1:0];

    // covariance output: signed clamp
    if (!sxy_q[63]) begin
      cov_res = (res_lo > 64'h0000_007F_FFFF_FFFF) ? 40'h7F_FFFF_FFFF
                                                   : res_lo[rcov_pkg::VAR_BITS-1:0];
    end else begin
      cov_res = (res_lo > 64'h0000_0080_0000_0000) ? 40'h80_0000_0000
                                                   : 40'(-res_lo);
    end
  end

  // ---- sequencer ----
  logic out_load;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= rcov_pkg::OP_QX;
      count_q  <= '0;
      mean_x_q <= '0;
      mean_y_q <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      sxy_q    <= '0;
      min_x_q  <= '0;
      max_x_q  <= '0;
      min_y_q  <= '0;
      max_y_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load)                             out_valid_q <= 1'b1;
      else if (m_axis_tready_i)                 out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_full) begin
              op_q    <= rcov_pkg::OP_VX;
              state_q <= (count_q > COUNT_BITS'(1)) ? ST_LAUNCH : ST_EMIT;
            end else begin
              count_q <= n_next;
              if (n_next == COUNT_BITS'(1)) begin
                // first sample seeds means and extremes
                mean_x_q <= sat32(48'(in_xw));
                mean_y_q <= sat32(48'(in_yw));
                min_x_q  <= in_x;
                max_x_q  <= in_x;
                min_y_q  <= in_y;
                max_y_q  <= in_y;
                state_q  <= ST_EMIT;
              end else begin
                if (in_x < min_x_q) min_x_q <= in_x;
                if (in_x > max_x_q) max_x_q <= in_x;
                if (in_y < min_y_q) min_y_q <= in_y;
                if (in_y > max_y_q) max_y_q <= in_y;
                op_q    <= rcov_pkg::OP_QX;
                state_q <= ST_LAUNCH;
              end
            end
          end
        end
        ST_LAUNCH: state_q <= ST_BUSY;
        ST_BUSY: begin
          if (unit_done) state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          state_q <= ST_LAUNCH;
          unique case (op_q)
            rcov_pkg::OP_QX: begin mean_x_q <= new_mean; op_q <= rcov_pkg::OP_QY; end
            rcov_pkg::OP_QY: begin mean_y_q <= new_mean; op_q <= rcov_pkg::OP_MX; end
            rcov_pkg::OP_MX: begin sx_q <= sat_add64(sx_q, scaled); op_q <= rcov_pkg::OP_MY; end
            rcov_pkg::OP_MY: begin sy_q <= sat_add64(sy_q, scaled); op_q <= rcov_pkg::OP_MP; end
            rcov_pkg::OP_MP: op_q <= rcov_pkg::OP_QP;
            rcov_pkg::OP_QP: begin
              sxy_q <= sat_add64(sxy_q, qp_term);
              op_q  <= rcov_pkg::OP_VX;
            end
            rcov_pkg::OP_VX: op_q <= rcov_pkg::OP_VY;
            rcov_pkg::OP_VY: op_q <= rcov_pkg::OP_CV;
            rcov_pkg::OP_CV: state_q <= ST_EMIT;
            default:         state_q <= ST_EMIT;
          endcase
        end
        ST_EMIT: begin
          if (out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q     <= in_x;
      y_q     <= in_y;
      dx_q    <= in_xw - DB'(mean_x_q);
      dy_q    <= in_yw - DB'(mean_y_q);
      full_q  <= is_full;
      var_x_q <= '0;
      var_y_q <= '0;
      cov_q   <= '0;
    end
    if (state_q == ST_APPLY) begin
      unique case (op_q)
        rcov_pkg::OP_MP: p_q     <= scaled;
        rcov_pkg::OP_VX: var_x_q <= var_res;
        rcov_pkg::OP_VY: var_y_q <= var_res;
        rcov_pkg::OP_CV: cov_q   <= cov_res;
        default: ;
      endcase
    end
    if (out_load) begin
      out_data_q <= {16'(max_y_q), 16'(min_y_q), 16'(max_x_q), 16'(min_x_q),
                     cov_q, var_y_q, var_x_q, mean_y_q, mean_x_q, 32'(count_q)};
      out_full_q <= full_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_full_q;

  // ---- assertions ----
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input taken while a sample is in work");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("sample count went backward");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_EMIT))
    else $error("result word raised outside emit step");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (state_q == ST_BUSY))
    else $error("serial unit finished outside busy step");

endmodule

`default_nettype wire

/* tb/running_covariance_accumulator_unit_tb.sv */
// ----------------------------------------------------------------------------
// running_covariance_accumulator_unit_tb: self-checking bench
// Streams (x, y) sample pairs into the accumulator with bursty input timing
// and a stalling receiver. A scoreboard predicts count, means, variances,
// covariance and extremes for every sample and checks each output word
// field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class cov_scoreboard;
  // predicted output words, oldest first
  logic [rcov_pkg::OUT_BITS-1:0] pending_words[$];
  logic                          pending_full[$];
  int                            errors;

  // accumulator state
  longint unsigned n_seen;
  longint          mean_x, mean_y, dsum_x, dsum_y, csum;
  longint          lo_x, hi_x, lo_y, hi_y;

  function void clear();
    n_seen = 0; mean_x = 0; mean_y = 0;
    dsum_x = 0; dsum_y = 0; csum = 0;
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    errors = 0;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? 64'h8000000000000000
                                                       : 64'h7fffffffffffffff;
    return s;
  endfunction

  // (a*b) >> 24 on magnitudes, saturated, sign restored
  function longint prod_scaled(longint a, longint b);
    logic [127:0] ma, mb, pr;
    longint       r;
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    ma[127:64] = '0;
    mb[127:64] = '0;
    pr = (ma * mb) >> 24;
    r  = (pr > 128'h7fffffffffffffff) ? 64'h7fffffffffffffff : longint'(pr[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function logic [39:0] var_out(longint s, longint d);
    longint q;
    if (s <= 0) return '0;
    q = s / d;
    if (q > 64'hffffffffff) q = 64'hffffffffff;
    return q[39:0];
  endfunction

  function logic [39:0] cov_out(longint s, longint d);
    longint q;
    q = s / d;
    if (q > 64'sd549755813887) q = 64'sd549755813887;
    if (q < -64'sd549755813888) q = -64'sd549755813888;
    return q[39:0];
  endfunction

  // accepted input word: advance state, queue the predicted result
  function void note_sample(logic signed [15:0] sx, logic signed [15:0] sy);
    longint x, y, bx, by, dx, dy, nx, ny, p, n;
    logic   full;
    logic [rcov_pkg::OUT_BITS-1:0] w;
    x = sx; y = sy;
    full = (n_seen == 64'hffffffff);
    if (!full) begin
      bx = x <<< 16;
      by = y <<< 16;
      n_seen++;
      if (n_seen == 1) begin
        mean_x = clamp32(bx); mean_y = clamp32(by);
        lo_x = x; hi_x = x; lo_y = y; hi_y = y;
      end else begin
        n  = longint'(n_seen);
        dx = bx - mean_x;
        dy = by - mean_y;
        nx = clamp32(mean_x + dx / n);
        ny = clamp32(mean_y + dy / n);
        p  = prod_scaled(dx, dy);
        dsum_x = add_sat(dsum_x, prod_scaled(dx, bx - nx));
        dsum_y = add_sat(dsum_y, prod_scaled(dy, by - ny));
        csum   = add_sat(csum, p - p / n);
        mean_x = nx; mean_y = ny;
        if (x < lo_x) lo_x = x;
        if (x > hi_x) hi_x = x;
        if (y < lo_y) lo_y = y;
        if (y > hi_y) hi_y = y;
      end
    end
    w = '0;
    w[31:0]  = n_seen[31:0];
    w[63:32] = mean_x[31:0];
    w[95:64] = mean_y[31:0];
    if (n_seen > 1) begin
      w[135:96]  = var_out(dsum_x, longint'(n_seen) - 1);
      w[175:136] = var_out(dsum_y, longint'(n_seen) - 1);
      w[215:176] = cov_out(csum, longint'(n_seen) - 1);
    end
    w[231:216] = lo_x[15:0];
    w[247:232] = hi_x[15:0];
    w[263:248] = lo_y[15:0];
    w[279:264] = hi_y[15:0];
    pending_words.push_back(w);
    pending_full.push_back(full);
  endfunction

  function void cmp_field(string tag, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, tag, e, a);
      errors++;
    end
  endfunction

  // accepted output word: check against the oldest prediction
  function void check_result(logic [rcov_pkg::OUT_BITS-1:0] a, logic f);
    logic [rcov_pkg::OUT_BITS-1:0] e;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected output word, expected none, got %h", $realtime, a);
      errors++;
      return;
    end
    e = pending_words.pop_front();
    cmp_field("sample_count", e[31:0], a[31:0]);
    cmp_field("average_x", e[63:32], a[63:32]);
    cmp_field("average_y", e[95:64], a[95:64]);
    cmp_field("variance_x", e[135:96], a[135:96]);
    cmp_field("variance_y", e[175:136], a[175:136]);
    cmp_field("covariance_xy", e[215:176], a[215:176]);
    cmp_field("smallest_x", e[231:216], a[231:216]);
    cmp_field("largest_x", e[247:232], a[247:232]);
    cmp_field("smallest_y", e[263:248], a[263:248]);
    cmp_field("largest_y", e[279:264], a[279:264]);
    cmp_field("count_full", 64'(pending_full.pop_front()), 64'(f));
  endfunction
endclass

module running_covariance_accumulator_unit_tb;

  localparam int RAND_SAMPLES = 1880;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [31:0]                   s_axis_tdata = '0;  // sample_x [15:0], sample_y [31:16]
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [rcov_pkg::OUT_BITS-1:0] m_axis_tdata;
  logic [0:0]                    m_axis_tuser;

  cov_scoreboard stats_sb = new();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  running_covariance_accumulator_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  // both handshakes observed with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      stats_sb.note_sample(s_axis_tdata[15:0], s_axis_tdata[31:16]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      stats_sb.check_result(m_axis_tdata, m_axis_tuser[0]);
  end

  // receiver: alternating phases of always-ready and random stalls
  int stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 4000;
    if (stall_phase < 1500) m_axis_tready <= 1'b1;
    else if (stall_phase < 3000) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= ($urandom_range(0, 7) == 0);
  end

  // one word; valid stays high when the next word follows back to back
  task automatic send_sample(logic [15:0] sx, logic [15:0] sy, bit keep_valid);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sy, sx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (!keep_valid) s_axis_tvalid <= 1'b0;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_value(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 64) - 32);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 2000) + 1000);
    endcase
  endfunction

  logic [15:0] dir_x[$] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h7fff, 16'h8000,
                            16'h0001, 16'h5555, 16'haaaa, 16'h7fff, 16'h8000, 16'h0000};
  logic [15:0] dir_y[$] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h7fff, 16'h8000,
                            16'hfffe, 16'haaaa, 16'h5555, 16'h8000, 16'h7fff, 16'h0000};

  initial begin
    int burst;
    int kind;
    stats_sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first sample with count one, extremes, sign flips
    foreach (dir_x[i]) send_sample(dir_x[i], dir_y[i], 1'b0);

    // random bursts
    for (int i = 0; i < RAND_SAMPLES; ) begin
      burst = $urandom_range(1, 8);
      kind  = $urandom_range(0, 3);
      for (int j = 0; j < burst && i < RAND_SAMPLES; j++, i++)
        send_sample(pick_value(kind), pick_value($urandom_range(0, 3)),
                    (j + 1 < burst) && (i + 1 < RAND_SAMPLES));
      // drain around the midpoint so the block runs dry
      if (i >= RAND_SAMPLES / 2 && i < RAND_SAMPLES / 2 + burst)
        while (stats_sb.pending_words.size() != 0) @(posedge clk_i);
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 40));
    end

    while (stats_sb.pending_words.size() != 0) @(posedge clk_i);
    idle_cycles(700);
    if (stats_sb.errors == 0 && stats_sb.pending_words.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #12000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
